### sv/vftg_pkg.sv
// Package for the video frame timestamp generator.
// Holds timing mode codes, register indexes, controller states and
// the command/status structs shared by the controller and datapath.
`default_nettype none
package vftg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 200;

  localparam logic [63:0] RefPerSec = 64'd10000000;

  // timing modes
  localparam logic [2:0] MODE_RATIONAL   = 3'd0;
  localparam logic [2:0] MODE_CLK_SMART  = 3'd1;
  localparam logic [2:0] MODE_CLK_THEO   = 3'd2;
  localparam logic [2:0] MODE_CLK_CLOCK  = 3'd3;
  localparam logic [2:0] MODE_CLK_NONE   = 3'd4;
  localparam logic [2:0] MODE_THEO_THEO  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_TIMING_MODE     = 3'd0;
  localparam logic [2:0] REG_FRAME_PERIOD    = 3'd1;
  localparam logic [2:0] REG_RATE_TIMESCALE  = 3'd2;
  localparam logic [2:0] REG_PERIOD_TICKS    = 3'd3;
  localparam logic [2:0] REG_CORRECTED_TICKS = 3'd4;
  localparam logic [2:0] REG_DRIFT_ENABLE    = 3'd5;
  localparam logic [2:0] REG_CLOCK_RATE      = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_BOOK, S_R_M1, S_R_M2, S_R_DIV, S_C_DIV1, S_C_MQ, S_C_MR,
    S_C_DIV2, S_C_OFS, S_T_MUL, S_FIN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    STEP_NONE, STEP_R_M1, STEP_R_M2, STEP_R_DIV, STEP_C_DIV1, STEP_C_MQ,
    STEP_C_MR, STEP_C_DIV2, STEP_T_MUL
  } step_e;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_e;

  typedef struct packed {
    logic  take;    // latch the accepted frame item
    logic  clr;     // timeline reset item
    logic  book;    // counter bookkeeping
    logic  go;      // launch the serial unit
    step_e step;
    logic  phase;   // 0 start, 1 stop in rational mode
    logic  ofs;     // apply clock offset
    logic  fin;     // load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       out_free;
    logic [2:0] mode;
  } dp_status_t;

endpackage
`default_nettype wire

### sv/vftg_arith.sv
// Serial 64-bit unit: shift-add multiply modulo 2^64, restoring divide.
// One bit per cycle. Uses vftg_pkg.
`default_nettype none
module vftg_arith
  import vftg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire arith_op_e   op_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      prod_o,
  output logic [63:0]      quot_o,
  output logic [63:0]      rem_o
);

  logic [63:0] a_q, b_q, acc_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  arith_op_e   op_q;
  logic [64:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, a_q[63]};
  assign ge      = rem_sh >= {1'b0, b_q};
  assign rem_sub = rem_sh - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (op_q == OP_MUL) begin
          if (b_q[0]) acc_q <= acc_q + a_q;
          a_q <= {a_q[62:0], 1'b0};
          b_q <= {1'b0, b_q[63:1]};
        end else begin
          rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
          a_q   <= {a_q[62:0], ge};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;
  assign quot_o = a_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### sv/vftg_datapath.sv
// Datapath: configuration registers, timeline state, operand selection,
// the serial arithmetic unit and the output register. Uses vftg_pkg, vftg_arith.
`default_nettype none
module vftg_datapath
  import vftg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o
);

  // configuration
  logic [2:0]  mode_q;
  logic [23:0] fp_q;
  logic [31:0] ts_q, pt_q, ct_q, rate_q;
  logic        drift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RATIONAL;
      fp_q    <= 24'd400000;
      ts_q    <= 32'd25;
      pt_q    <= 32'd1;
      ct_q    <= 32'd1;
      drift_q <= 1'b0;
      rate_q  <= 32'd10000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMING_MODE:     mode_q  <= cfg_data_i[2:0];
        REG_FRAME_PERIOD:    fp_q    <= cfg_data_i[23:0];
        REG_RATE_TIMESCALE:  ts_q    <= cfg_data_i;
        REG_PERIOD_TICKS:    pt_q    <= cfg_data_i;
        REG_CORRECTED_TICKS: ct_q    <= cfg_data_i;
        REG_DRIFT_ENABLE:    drift_q <= cfg_data_i[0];
        REG_CLOCK_RATE:      rate_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [63:0] ts_eff, rate_eff, t_eff;
  assign ts_eff   = {32'd0, (ts_q == '0) ? 32'd1 : ts_q};
  assign rate_eff = {32'd0, (rate_q == '0) ? 32'd1 : rate_q};
  assign t_eff    = {32'd0, drift_q ? ct_q : pt_q};

  // latched item
  logic [63:0] src_q;
  logic [62:0] cap_q, next_q;
  logic        next_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      src_q     <= in_data_i[63:0];
      cap_q     <= in_data_i[126:64];
      next_q    <= in_data_i[189:127];
      next_ok_q <= in_data_i[190];
    end
  end

  // timeline state and per-item work registers
  logic [63:0] local_cnt_q, prev_src_q, cnt_ofs_q, time_ofs_q, prev_stop_q;
  logic        force_disc_q, pend_seg_q;
  logic [63:0] stream_q, t_q, u_q, start_q, stop_q;
  logic        disc_q, seg_q, inv_q;

  // serial unit
  logic        busy, done;
  logic [63:0] prod, quot, rem;
  logic [63:0] op_a, op_b;
  arith_op_e   op;

  always_comb begin
    op   = OP_MUL;
    op_a = t_q;
    op_b = RefPerSec;
    case (cmd_i.step)
      STEP_R_M1: begin
        op_a = cmd_i.phase ? stream_q + 64'd1 : stream_q;
        op_b = t_eff;
      end
      STEP_R_M2: ;
      STEP_R_DIV: begin
        op   = OP_DIV;
        op_b = ts_eff;
      end
      STEP_C_DIV1: begin
        op   = OP_DIV;
        op_a = {1'b0, cap_q};
        op_b = rate_eff;
      end
      STEP_C_MQ: ;
      STEP_C_MR: op_a = u_q;
      STEP_C_DIV2: begin
        op   = OP_DIV;
        op_a = u_q;
        op_b = rate_eff;
      end
      STEP_T_MUL: begin
        op_a = stream_q;
        op_b = {40'd0, fp_q};
      end
      default: ;
    endcase
  end

  vftg_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go),
    .op_i   (op),
    .a_i    (op_a),
    .b_i    (op_b),
    .busy_o (busy),
    .done_o (done),
    .prod_o (prod),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // bookkeeping terms
  logic        rep, fd, disc;
  logic [63:0] lc, co;
  assign rep  = (mode_q == MODE_RATIONAL) && (time_ofs_q != '0);
  assign fd   = rep | force_disc_q;
  assign lc   = local_cnt_q + 64'd1;
  assign co   = (cnt_ofs_q == '0) ? src_q : cnt_ofs_q;
  assign disc = (src_q != prev_src_q + 64'd1) || (lc == 64'd1) || fd;

  // rational inversion repair
  logic        inv_hit;
  assign inv_hit = (stream_q != '0) &&
                   ({~quot[63], quot[62:0]} <= {~prev_stop_q[63], prev_stop_q[62:0]});

  // stop selection
  logic        has_stop;
  logic [63:0] fin_stop, start_fp;
  assign start_fp = start_q + {40'd0, fp_q};
  always_comb begin
    has_stop = 1'b1;
    fin_stop = start_fp;
    case (mode_q)
      MODE_RATIONAL:  fin_stop = stop_q;
      MODE_CLK_SMART, MODE_CLK_CLOCK:
        fin_stop = next_ok_q ? ({1'b0, next_q} - time_ofs_q) : start_fp;
      MODE_CLK_THEO, MODE_THEO_THEO: fin_stop = start_fp;
      default: begin
        has_stop = 1'b0;
        fin_stop = '0;
      end
    endcase
  end

  logic out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_cnt_q  <= '0;
      prev_src_q   <= '0;
      cnt_ofs_q    <= '0;
      time_ofs_q   <= '0;
      prev_stop_q  <= '0;
      force_disc_q <= 1'b0;
      pend_seg_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.clr) begin
        local_cnt_q <= '0;
        prev_src_q  <= '0;
        cnt_ofs_q   <= '0;
        time_ofs_q  <= '0;
        prev_stop_q <= '0;
      end
      if (cmd_i.book) begin
        if (rep) begin
          time_ofs_q  <= '0;
          prev_stop_q <= '0;
        end
        local_cnt_q  <= lc;
        cnt_ofs_q    <= co;
        force_disc_q <= disc ? 1'b0 : fd;
        pend_seg_q   <= 1'b0;
        prev_src_q   <= src_q;
      end
      if (cmd_i.ofs && time_ofs_q == '0) time_ofs_q <= start_q;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        if (has_stop) prev_stop_q <= fin_stop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.book) begin
      stream_q <= src_q - co;
      disc_q   <= disc;
      seg_q    <= rep | pend_seg_q;
      inv_q    <= 1'b0;
      start_q  <= '0;
    end
    if (done) begin
      case (cmd_i.step)
        STEP_R_M1, STEP_R_M2, STEP_C_MQ: t_q <= prod;
        STEP_R_DIV: begin
          if (cmd_i.phase) begin
            stop_q <= quot;
          end else if (inv_hit) begin
            start_q <= prev_stop_q + 64'd1;
            inv_q   <= 1'b1;
          end else begin
            start_q <= quot;
          end
        end
        STEP_C_DIV1: begin
          t_q <= quot;
          u_q <= rem;
        end
        STEP_C_MR:   u_q <= prod;
        STEP_C_DIV2: start_q <= t_q + quot;
        STEP_T_MUL:  start_q <= prod;
        default: ;
      endcase
    end
    if (cmd_i.ofs) start_q <= (time_ofs_q == '0) ? '0 : start_q - time_ofs_q;
    if (cmd_i.fin) begin
      out_data_q <= {4'd0, inv_q, seg_q, disc_q, has_stop, fin_stop, start_q, stream_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.busy     = busy;
  assign status_o.done     = done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.mode     = mode_q;

endmodule
`default_nettype wire

### sv/vftg_ctrl.sv
// Controller state machine: sequences bookkeeping, serial operations
// and output loading for one item. Uses vftg_pkg.
`default_nettype none
module vftg_ctrl
  import vftg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_kind_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        phase_q, phase_d;
  logic        unit_idle;

  assign unit_idle = !status_i.busy && !status_i.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_kind_i) state_d = S_BOOK;
      S_BOOK: begin
        phase_d = 1'b0;
        case (status_i.mode)
          MODE_RATIONAL: state_d = S_R_M1;
          MODE_CLK_SMART, MODE_CLK_THEO, MODE_CLK_CLOCK, MODE_CLK_NONE:
            state_d = S_C_DIV1;
          default: state_d = S_T_MUL;
        endcase
      end
      S_R_M1:   if (status_i.done) state_d = S_R_M2;
      S_R_M2:   if (status_i.done) state_d = S_R_DIV;
      S_R_DIV: begin
        if (status_i.done) begin
          phase_d = 1'b1;
          state_d = phase_q ? S_FIN : S_R_M1;
        end
      end
      S_C_DIV1: if (status_i.done) state_d = S_C_MQ;
      S_C_MQ:   if (status_i.done) state_d = S_C_MR;
      S_C_MR:   if (status_i.done) state_d = S_C_DIV2;
      S_C_DIV2: if (status_i.done) state_d = S_C_OFS;
      S_C_OFS:  state_d = S_FIN;
      S_T_MUL:  if (status_i.done) state_d = S_FIN;
      S_FIN:    if (status_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.step  = STEP_NONE;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        cmd_o.clr  = in_valid_i && in_kind_i;
      end
      S_BOOK:   cmd_o.book = 1'b1;
      S_R_M1:   cmd_o.step = STEP_R_M1;
      S_R_M2:   cmd_o.step = STEP_R_M2;
      S_R_DIV:  cmd_o.step = STEP_R_DIV;
      S_C_DIV1: cmd_o.step = STEP_C_DIV1;
      S_C_MQ:   cmd_o.step = STEP_C_MQ;
      S_C_MR:   cmd_o.step = STEP_C_MR;
      S_C_DIV2: cmd_o.step = STEP_C_DIV2;
      S_T_MUL:  cmd_o.step = STEP_T_MUL;
      S_C_OFS:  cmd_o.ofs = 1'b1;
      S_FIN:    cmd_o.fin = status_i.out_free;
      default: ;
    endcase
    cmd_o.go = (cmd_o.step != STEP_NONE) && unit_idle;
  end

endmodule
`default_nettype wire

### sv/video_frame_timestamp_gen_unit.sv
// Top level of the video frame timestamp generator.
// Joins vftg_ctrl and vftg_datapath; uses vftg_pkg.
//
// Usage:
//  - Slave stream takes one item per frame: tuser is the kind (frame or
//    timeline reset), tdata the counter, capture time and next-frame time.
//  - A timeline reset item is absorbed in its accept cycle and yields no result.
//  - A frame item yields one result on the master stream: media index,
//    start/stop times in 100 ns units and the frame flags.
//  - Every multiply and divide runs on one shared serial unit, one bit per
//    cycle. An item takes six operations in rational mode, four in the
//    clock modes and one in the nominal-period modes.
//  - One item is in work at a time; the next is taken once the result is
//    loaded into the output register, even while that result still waits.
//  - When the receiver stalls, hold the result; a second finished item
//    waits in the controller until the output register frees.
//  - Reset clears the timeline state and loads register defaults.
//  - Configuration writes take effect at once; write only while idle.
`default_nettype none
module video_frame_timestamp_gen_unit
  import vftg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [63:0] source_count, [126:64] capture_ticks, [189:127] next_time,
  // [190] next_present, [191] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [63:0] media_index, [127:64] start_time, [191:128] stop_time,
  // [192] stop_present, [193] discontinuous, [194] new_segment,
  // [195] inversion_fixed, [199:196] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  vftg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vftg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
